@@ src/cpx_pkg.sv @@
// Package for the chunk packetizer with XOR parity: field widths, command,
// status and register codes, header flag masks and the result record.
// No dependencies; the interfaces, the top level, the checker and the bench import it.
package cpx_pkg;

    localparam int CMD_W     = 2;
    localparam int BYTE_W    = 8;
    localparam int PSZ_W     = 18;
    localparam int FLAG_W    = 16;
    localparam int NUM_W     = 6;
    localparam int TOT_W     = 7;
    localparam int OFF_W     = 17;
    localparam int LEN_W     = 12;
    localparam int ST_W      = 2;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_BYTE  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ABORT = 2'd2;

    localparam logic [ST_W-1:0] ST_OK      = 2'd0;
    localparam logic [ST_W-1:0] ST_BADSIZE = 2'd1;
    localparam logic [ST_W-1:0] ST_ABORTED = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_BYTES = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERLEAVE  = 1'd1;

    localparam logic [CFG_W-1:0] CHUNK_BYTES_RST = 12'd1200;

    localparam logic [FLAG_W-1:0] FL_FIRST  = 16'h0002;
    localparam logic [FLAG_W-1:0] FL_LAST   = 16'h0004;
    localparam logic [FLAG_W-1:0] FL_PARITY = 16'h0010;
    localparam logic [FLAG_W-1:0] FL_ILV    = 16'h0020;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic [FLAG_W-1:0] packet_flags;
        logic [NUM_W-1:0]  chunk_number;
        logic [TOT_W-1:0]  chunks_in_frame;
        logic [OFF_W-1:0]  chunk_start_offset;
        logic [LEN_W-1:0]  chunk_length;
        logic              packet_end;
        logic              frame_done;
        logic [ST_W-1:0]   status;
    } t_out;

endpackage

@@ src/cpx_if.sv @@
// Request and result channel interfaces of the chunk packetizer.
// Depends on cpx_pkg for field widths.
interface cpx_in_if;
    import cpx_pkg::*;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [BYTE_W-1:0] byte_value;
    logic [PSZ_W-1:0]  payload_size;
    logic [FLAG_W-1:0] base_flags;
    modport source (output valid, command, byte_value, payload_size, base_flags,
                    input ready);
    modport sink   (input valid, command, byte_value, payload_size, base_flags,
                    output ready);
endinterface

interface cpx_out_if;
    import cpx_pkg::*;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic [FLAG_W-1:0] packet_flags;
    logic [NUM_W-1:0]  chunk_number;
    logic [TOT_W-1:0]  chunks_in_frame;
    logic [OFF_W-1:0]  chunk_start_offset;
    logic [LEN_W-1:0]  chunk_length;
    logic              packet_end;
    logic              frame_done;
    logic [ST_W-1:0]   status;
    modport source (output valid, out_byte, packet_flags, chunk_number,
                    chunks_in_frame, chunk_start_offset, chunk_length,
                    packet_end, frame_done, status, input ready);
    modport sink   (input valid, out_byte, packet_flags, chunk_number,
                    chunks_in_frame, chunk_start_offset, chunk_length,
                    packet_end, frame_done, status, output ready);
endinterface

@@ src/chunk_packetizer_xor_fec.sv @@
// Top level of the chunk packetizer with XOR parity groups.
// Depends on cpx_pkg, cpx_if, cpx_div and cpx_pmem.
//
//  channel    dir  handshake     carries
//  i_in_ch    in   valid/ready   command, byte_value, payload_size, base_flags
//  o_out_ch   out  valid/ready   one tagged data, parity or status byte
//  i_cfg_*    in   write enable  chunk_payload_bytes, interleave_enable
//
// Each request passes the parity store read, then the output register; a new data
// byte or drain tick is taken while earlier ones are in flight, unless the output stalls.
// Before the first byte of a frame goes on, the shared divider, of quotient width
// QW = clog2(MAX_CHUNKS+1), finds the chunk count and then the group count.
// The parity store needs no clearing pass: the first chunk of each group
// overwrites its entries, later chunks read, XOR and write back.
// A stalled output holds the stage behind it and then the request channel.
module chunk_packetizer_xor_fec #(
    parameter int GROUP_SIZE      = 8,
    parameter int MAX_CHUNKS      = 64,
    parameter int MAX_CHUNK_BYTES = 2048
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [cpx_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [cpx_pkg::CFG_W-1:0]         i_cfg_data,
    cpx_in_if.sink                            i_in_ch,
    cpx_out_if.source                         o_out_ch
);
    import cpx_pkg::*;

    localparam int GROUPS_MAX = (MAX_CHUNKS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int CW  = $clog2(MAX_CHUNKS + 1);
    localparam int GW  = $clog2(GROUPS_MAX + 1);
    localparam int BW  = $clog2(MAX_CHUNK_BYTES);
    localparam int IW  = $clog2(GROUP_SIZE);
    localparam int AW  = GW + BW;
    localparam int MW  = CW + LEN_W;
    localparam int NW  = PSZ_W + 1;
    localparam int DDW = LEN_W + IW;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_DIV   = 5'b00010,
        S_FIRST = 5'b00100,
        S_DATA  = 5'b01000,
        S_DRAIN = 5'b10000
    } t_state;

    typedef enum logic [1:0] {
        K_DATA,
        K_PAR,
        K_STAT
    } t_kind;

    // configuration
    logic [CFG_W-1:0] r_cfg_cs;
    logic             r_cfg_ilv;

    // frame context
    t_state            r_state;
    logic              r_pass;
    logic [LEN_W-1:0]  r_cs;
    logic              r_ilv;
    logic [PSZ_W-1:0]  r_psz;
    logic [FLAG_W-1:0] r_flags;
    logic [BYTE_W-1:0] r_byte0;
    logic [CW-1:0]     r_cnt;
    logic [GW-1:0]     r_gtot;
    logic [MW-1:0]     r_cs_step;
    logic [CW-1:0]     r_chunk;
    logic [BW-1:0]     r_bic;
    logic [PSZ_W-1:0]  r_off;
    logic [PSZ_W-1:0]  r_foff;
    logic [GW-1:0]     r_grp;
    logic [IW-1:0]     r_ing;
    logic [LEN_W-1:0]  r_last_len;
    logic [GW-1:0]     r_dg;
    logic [BW-1:0]     r_db;
    logic [CW-1:0]     r_dfirst;
    logic [MW-1:0]     r_doff;

    // read stage and output register
    logic              r_s1_v;
    t_kind             r_s1_kind;
    t_out              r_s1_pay;
    logic [AW-1:0]     r_s1_addr;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_ovw;
    logic              r_s1_zero;
    logic              r_o_v;
    t_out              r_o_pay;

    logic [LEN_W-1:0] w_cs_in;
    logic [MW-1:0]    w_limit;
    logic             w_invalid;
    logic             w_s1_adv, w_s1_free, w_ready, w_acc;
    logic             w_first_go, w_byte_go, w_drain_go;
    logic             w_start, w_bad_go, w_abort_go;
    logic [BYTE_W-1:0] w_byte;
    logic [PSZ_W-1:0] w_rem;
    logic [LEN_W-1:0] w_len;
    logic             w_last, w_pend, w_fend, w_fresh;
    logic [FLAG_W-1:0] w_dflags, w_pflags;
    logic [AW-1:0]    w_addr, w_daddr;
    logic             w_dpend, w_ddone, w_dzero;
    logic             w_div_start, w_div_done;
    logic [NW-1:0]    w_div_num;
    logic [DDW-1:0]   w_div_den;
    logic [DDW-1:0]   w_grp_bytes;
    logic [CW-1:0]    w_quo;
    logic [7:0]       w_rdata;
    logic             w_wr_en;
    logic [7:0]       w_wr_data;
    t_out             w_res;

    // clamp the chunk size register to the store's row length
    assign w_cs_in = ({5'd0, r_cfg_cs} > 17'(MAX_CHUNK_BYTES)) ?
                     LEN_W'(MAX_CHUNK_BYTES) : r_cfg_cs;
    assign w_limit = MW'(MAX_CHUNKS) * MW'(w_cs_in);
    assign w_invalid = (i_in_ch.payload_size == '0) || (w_cs_in == '0) ||
                       (MW'(i_in_ch.payload_size) > w_limit);

    // handshake
    assign w_s1_adv  = r_s1_v && (!r_o_v || o_out_ch.ready);
    assign w_s1_free = !r_s1_v || w_s1_adv;
    assign w_ready   = w_s1_free &&
                       (r_state == S_IDLE || r_state == S_DATA || r_state == S_DRAIN);
    assign w_acc     = i_in_ch.valid && w_ready;
    assign i_in_ch.ready = w_ready;

    assign w_first_go = (r_state == S_FIRST) && w_s1_free;
    assign w_byte_go  = w_first_go ||
                        (w_acc && i_in_ch.command == CMD_BYTE && r_state == S_DATA);
    assign w_drain_go = w_acc && i_in_ch.command == CMD_DRAIN && r_state == S_DRAIN;
    assign w_start    = w_acc && i_in_ch.command == CMD_BYTE && r_state == S_IDLE &&
                        !w_invalid;
    assign w_bad_go   = w_acc && i_in_ch.command == CMD_BYTE && r_state == S_IDLE &&
                        w_invalid;
    assign w_abort_go = w_acc && i_in_ch.command == CMD_ABORT &&
                        (r_state == S_DATA || r_state == S_DRAIN);
    assign w_byte     = w_first_go ? r_byte0 : i_in_ch.byte_value;

    // data byte header
    assign w_rem  = r_psz - r_off;
    assign w_len  = (w_rem > PSZ_W'(r_cs)) ? r_cs : w_rem[LEN_W-1:0];
    assign w_last = (NW'(r_off) + NW'(w_len)) >= NW'(r_psz);
    assign w_pend = (17'(r_bic) + 17'd1) >= 17'(w_len);
    assign w_fend = (NW'(r_foff) + NW'(1)) >= NW'(r_psz);
    assign w_fresh = r_ilv ? (r_chunk < CW'(r_gtot)) : (r_ing == '0);
    assign w_addr = {r_grp, r_bic};
    assign w_dflags = (r_flags & ~(FL_FIRST | FL_LAST | FL_PARITY)) |
                      ((r_off == '0) ? FL_FIRST : '0) | (w_last ? FL_LAST : '0);

    // parity packet header
    assign w_dpend = (17'(r_db) + 17'd1) >= 17'(r_cs);
    assign w_ddone = w_dpend && ((GW'(r_dg) + GW'(1)) >= r_gtot);
    // a lone short final chunk leaves the tail of its row unwritten: read as zero
    assign w_dzero = (r_dfirst == (r_cnt - CW'(1))) && (LEN_W'(r_db) >= r_last_len);
    assign w_daddr = {r_dg, r_db};
    assign w_pflags = (r_flags & ~(FL_FIRST | FL_LAST)) | FL_PARITY |
                      (r_ilv ? FL_ILV : '0);

    // divider: chunk count, then group count as the frame over the group's bytes
    assign w_grp_bytes = DDW'(GROUP_SIZE) * DDW'(r_cs);
    assign w_div_start = w_start || (w_div_done && !r_pass);
    assign w_div_num   = w_start ? (NW'(i_in_ch.payload_size) + NW'(w_cs_in) - NW'(1)) :
                                   (NW'(r_psz) + NW'(w_grp_bytes) - NW'(1));
    assign w_div_den   = w_start ? DDW'(w_cs_in) : w_grp_bytes;

    cpx_div #(.NW(NW), .DW(DDW), .QW(CW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_quo)
    );

    // when the stage hands its result on, write back the XOR, or the byte alone for a group's first chunk
    assign w_wr_en   = w_s1_adv && (r_s1_kind == K_DATA);
    assign w_wr_data = r_s1_ovw ? r_s1_byte : (w_rdata ^ r_s1_byte);

    cpx_pmem #(.AW(AW)) u_pmem (
        .i_clk     (i_clk),
        .i_rd_en   (w_byte_go || w_drain_go),
        .i_rd_addr (w_byte_go ? w_addr : w_daddr),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rdata)
    );

    // result record from the stage: parity bytes take the store data, or zero past a lone short chunk's end
    always_comb begin
        w_res = r_s1_pay;
        if (r_s1_kind == K_PAR) begin
            w_res.out_byte = r_s1_zero ? '0 : w_rdata;
        end
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cs  <= CHUNK_BYTES_RST;
            r_cfg_ilv <= 1'b0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_CHUNK_BYTES: r_cfg_cs  <= i_cfg_data;
                REG_INTERLEAVE:  r_cfg_ilv <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pass  <= 1'b0;
            r_s1_v  <= 1'b0;
            r_o_v   <= 1'b0;
        end else begin
            if (w_start) begin
                r_state <= S_DIV;
                r_pass  <= 1'b0;
            end else if (w_div_done && !r_pass) begin
                r_pass <= 1'b1;
            end else if (w_div_done && r_pass) begin
                r_state <= S_FIRST;
            end else if (w_byte_go) begin
                r_state <= w_fend ? S_DRAIN : S_DATA;
            end else if (w_drain_go && w_ddone) begin
                r_state <= S_IDLE;
            end else if (w_abort_go) begin
                r_state <= S_IDLE;
            end

            if (w_byte_go || w_drain_go || w_bad_go || w_abort_go) begin
                r_s1_v <= 1'b1;
            end else if (w_s1_adv) begin
                r_s1_v <= 1'b0;
            end

            if (w_s1_adv) begin
                r_o_v <= 1'b1;
            end else if (o_out_ch.ready) begin
                r_o_v <= 1'b0;
            end
        end
    end

    // frame counters
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_cs      <= w_cs_in;
            r_ilv     <= r_cfg_ilv;
            r_psz     <= i_in_ch.payload_size;
            r_flags   <= i_in_ch.base_flags;
            r_byte0   <= i_in_ch.byte_value;
            r_cs_step <= r_cfg_ilv ? MW'(w_cs_in) : MW'(GROUP_SIZE) * MW'(w_cs_in);
            r_chunk   <= '0;
            r_bic     <= '0;
            r_off     <= '0;
            r_foff    <= '0;
            r_grp     <= '0;
            r_ing     <= '0;
        end
        if (w_div_done && !r_pass) begin
            r_cnt <= w_quo;
        end
        if (w_div_done && r_pass) begin
            r_gtot <= GW'(w_quo);
        end
        if (w_byte_go) begin
            r_foff <= r_foff + PSZ_W'(1);
            if (w_last) begin
                r_last_len <= w_len;
            end
            if (w_pend) begin
                r_chunk <= r_chunk + CW'(1);
                r_bic   <= '0;
                r_off   <= r_off + PSZ_W'(r_cs);
                if (r_ilv) begin
                    r_grp <= ((r_grp + GW'(1)) == r_gtot) ? '0 : r_grp + GW'(1);
                end else if (r_ing == IW'(GROUP_SIZE - 1)) begin
                    r_ing <= '0;
                    r_grp <= r_grp + GW'(1);
                end else begin
                    r_ing <= r_ing + IW'(1);
                end
            end else begin
                r_bic <= r_bic + BW'(1);
            end
            if (w_fend) begin
                r_dg     <= '0;
                r_db     <= '0;
                r_dfirst <= '0;
                r_doff   <= '0;
            end
        end
        if (w_drain_go) begin
            if (w_dpend) begin
                r_dg     <= r_dg + GW'(1);
                r_db     <= '0;
                r_dfirst <= r_dfirst + (r_ilv ? CW'(1) : CW'(GROUP_SIZE));
                r_doff   <= r_doff + r_cs_step;
            end else begin
                r_db <= r_db + BW'(1);
            end
        end
    end

    // read stage and output register payload
    always_ff @(posedge i_clk) begin
        if (w_byte_go) begin
            r_s1_kind <= K_DATA;
            r_s1_addr <= w_addr;
            r_s1_byte <= w_byte;
            r_s1_ovw  <= w_fresh;
            r_s1_zero <= 1'b0;
            r_s1_pay  <= '{out_byte: w_byte, packet_flags: w_dflags,
                           chunk_number: NUM_W'(r_chunk),
                           chunks_in_frame: TOT_W'(r_cnt),
                           chunk_start_offset: OFF_W'(r_off),
                           chunk_length: w_len, packet_end: w_pend,
                           frame_done: 1'b0, status: ST_OK};
        end else if (w_drain_go) begin
            r_s1_kind <= K_PAR;
            r_s1_zero <= w_dzero;
            r_s1_pay  <= '{out_byte: '0, packet_flags: w_pflags,
                           chunk_number: NUM_W'(r_dfirst),
                           chunks_in_frame: TOT_W'(r_cnt),
                           chunk_start_offset: OFF_W'(r_doff),
                           chunk_length: r_cs, packet_end: w_dpend,
                           frame_done: w_ddone, status: ST_OK};
        end else if (w_bad_go || w_abort_go) begin
            r_s1_kind <= K_STAT;
            r_s1_pay  <= '{out_byte: '0, packet_flags: '0, chunk_number: '0,
                           chunks_in_frame: '0, chunk_start_offset: '0,
                           chunk_length: '0, packet_end: 1'b0, frame_done: 1'b1,
                           status: w_bad_go ? ST_BADSIZE : ST_ABORTED};
        end
        if (w_s1_adv) begin
            r_o_pay <= w_res;
        end
    end

    assign o_out_ch.valid              = r_o_v;
    assign o_out_ch.out_byte           = r_o_pay.out_byte;
    assign o_out_ch.packet_flags       = r_o_pay.packet_flags;
    assign o_out_ch.chunk_number       = r_o_pay.chunk_number;
    assign o_out_ch.chunks_in_frame    = r_o_pay.chunks_in_frame;
    assign o_out_ch.chunk_start_offset = r_o_pay.chunk_start_offset;
    assign o_out_ch.chunk_length       = r_o_pay.chunk_length;
    assign o_out_ch.packet_end         = r_o_pay.packet_end;
    assign o_out_ch.frame_done         = r_o_pay.frame_done;
    assign o_out_ch.status             = r_o_pay.status;
endmodule

@@ src/cpx_div.sv @@
// Restoring divider, one quotient bit per cycle, for the chunk and group counts.
// Standalone; used by chunk_packetizer_xor_fec.
module cpx_div #(
    parameter int NW = 19,
    parameter int DW = 12,
    parameter int QW = 7
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [NW-1:0] i_num,
    input  logic [DW-1:0] i_den,
    output logic          o_done,
    output logic [QW-1:0] o_quo
);
    localparam int SW = NW + DW + QW;
    localparam int KW = (QW > 1) ? $clog2(QW) : 1;

    logic          r_busy;
    logic          r_done;
    logic [KW-1:0] r_k;
    logic [SW-1:0] r_rem;
    logic [SW-1:0] r_dsh;
    logic [QW-1:0] r_q;
    logic          w_fit;

    assign w_fit  = (r_rem >= r_dsh);
    assign o_done = r_done;
    assign o_quo  = r_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= r_busy && (r_k == '0);
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_k == '0)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= SW'(i_num);
            r_dsh <= SW'(i_den) << (QW - 1);
            r_k   <= KW'(QW - 1);
            r_q   <= '0;
        end else if (r_busy) begin
            if (w_fit) begin
                r_rem <= r_rem - r_dsh;
            end
            r_q   <= {r_q[QW-2:0], w_fit};
            r_dsh <= r_dsh >> 1;
            r_k   <= r_k - KW'(1);
        end
    end
endmodule

@@ src/cpx_pmem.sv @@
// Parity store: one-port-write, one-port-read synchronous RAM with write-to-read
// forwarding for a read issued in the cycle of a write to the same entry.
module cpx_pmem #(
    parameter int AW = 14
) (
    input  logic          i_clk,
    input  logic          i_rd_en,
    input  logic [AW-1:0] i_rd_addr,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [7:0]    i_wr_data,
    output logic [7:0]    o_rd_data
);
    logic [7:0] r_mem [2**AW];
    logic [7:0] r_rdata;
    logic       r_fwd_hit;
    logic [7:0] r_fwd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rdata    <= r_mem[i_rd_addr];
            r_fwd_hit  <= i_wr_en && (i_wr_addr == i_rd_addr);
            r_fwd_data <= i_wr_data;
        end
    end

    assign o_rd_data = r_fwd_hit ? r_fwd_data : r_rdata;
endmodule

@@ src/cpx_chk.sv @@
// Port-level checker for the chunk packetizer and its bind to the top level.
// Depends on cpx_pkg.
module cpx_chk (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [cpx_pkg::BYTE_W-1:0] i_out_byte,
    input logic [cpx_pkg::FLAG_W-1:0] i_flags,
    input logic [cpx_pkg::LEN_W-1:0]  i_len,
    input logic                       i_pend,
    input logic                       i_done,
    input logic [cpx_pkg::ST_W-1:0]   i_status
);
    import cpx_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_byte) &&
        $stable(i_flags) && $stable(i_status))
        else $error("stalled result changed");

    // status reports end the frame and carry no packet
    a_stat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != ST_OK) |->
        i_done && !i_pend && (i_len == '0) && (i_flags == '0))
        else $error("malformed status report");

    // a data byte never ends the frame
    a_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_OK) && ((i_flags & FL_PARITY) == '0) |->
        !i_done && (i_len != '0))
        else $error("data byte marked frame done");

    // frame done on a parity byte only on its packet's last byte
    a_pdone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status == ST_OK) && i_done |-> i_pend)
        else $error("frame done off a packet end");

    // nothing shows right after reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result after reset");
endmodule

bind chunk_packetizer_xor_fec cpx_chk u_cpx_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out_ch.valid),
    .i_out_ready (o_out_ch.ready),
    .i_out_byte  (o_out_ch.out_byte),
    .i_flags     (o_out_ch.packet_flags),
    .i_len       (o_out_ch.chunk_length),
    .i_pend      (o_out_ch.packet_end),
    .i_done      (o_out_ch.frame_done),
    .i_status    (o_out_ch.status)
);

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for chunk_packetizer_xor_fec: a directed table, then random frames.
// Each result is scored against a local packetizer and parity predictor, or against the row's own.
// Depends on cpx_pkg, cpx_if and the block's top level.
module tb_top;
    import cpx_pkg::*;

    localparam int GROUP_SIZE      = 8;
    localparam int MAX_CHUNKS      = 64;
    localparam int MAX_CHUNK_BYTES = 2048;
    localparam int GROUPS_MAX      = (MAX_CHUNKS + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int SETTLE_CYCLES   = 40;      // output pipe plus the divider on a first byte
    localparam int CYCLE_LIMIT     = 600000;
    localparam int RANDOM_ITEMS    = 960;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'b001,
        PH_DATA  = 3'b010,
        PH_DRAIN = 3'b100
    } t_frame_phase;
    typedef enum logic {ROW_REQ, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        logic [CMD_W-1:0]  cmd;
        logic [BYTE_W-1:0] bval;
        logic [PSZ_W-1:0]  psz;
        logic [FLAG_W-1:0] bflags;
        int                reps;
        bit                typed;      // expected result written out in the row
        t_out              exp;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_val;
    } t_stim_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx = '0;
    logic [CFG_W-1:0]     cfg_data = '0;

    cpx_in_if  in_ch();
    cpx_out_if out_ch();

    chunk_packetizer_xor_fec i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_in_ch    (in_ch),
        .o_out_ch   (out_ch)
    );

    always #4 i_clk = ~i_clk;

    // Register mirror and predicted frame state.
    int unsigned   reg_chunk_bytes = CHUNK_BYTES_RST;
    bit            reg_interleave  = 1'b0;
    logic [7:0]    parity_mem [0:GROUPS_MAX*MAX_CHUNK_BYTES-1];
    t_frame_phase  phase = PH_IDLE;
    int unsigned   lat_chunk, lat_size, lat_flags, chunk_total, group_total;
    int unsigned   cur_chunk, in_chunk, bytes_seen, drain_grp, drain_pos;
    bit            lat_ilv;

    t_out          expected_q[$];
    int            err_cnt = 0;
    int            cycles = 0;
    int            src_gap_pct = 0;
    int            snk_stall_pct = 0;

    // Advance the packetizer by one accepted request; return 1 with the result if one is due.
    function automatic bit packetize(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] bv,
                                     input logic [PSZ_W-1:0] psz, input logic [FLAG_W-1:0] bfl,
                                     output t_out r);
        int unsigned cs, cnt, off, len, grp, first;
        logic [FLAG_W-1:0] fl;
        bit pend, done;
        r = '0;
        case (cmd)
            CMD_ABORT: begin
                if (phase == PH_IDLE) return 1'b0;
                phase = PH_IDLE;
                r.frame_done = 1'b1;
                r.status     = ST_ABORTED;
                return 1'b1;
            end
            CMD_BYTE: begin
                if (phase == PH_DRAIN) return 1'b0;
                if (phase == PH_IDLE) begin
                    cs  = (reg_chunk_bytes > MAX_CHUNK_BYTES) ? MAX_CHUNK_BYTES : reg_chunk_bytes;
                    cnt = (psz == 0 || cs == 0) ? 0 : (32'(psz) + cs - 1) / cs;
                    if (cnt == 0 || cnt > MAX_CHUNKS) begin
                        r.frame_done = 1'b1;
                        r.status     = ST_BADSIZE;
                        return 1'b1;
                    end
                    foreach (parity_mem[i]) parity_mem[i] = '0;
                    lat_chunk   = cs;
                    lat_ilv     = reg_interleave;
                    lat_size    = 32'(psz);
                    lat_flags   = 32'(bfl);
                    chunk_total = cnt;
                    group_total = (cnt + GROUP_SIZE - 1) / GROUP_SIZE;
                    bytes_seen  = 0;
                    in_chunk    = 0;
                    cur_chunk   = 0;
                    phase       = PH_DATA;
                end
                off = cur_chunk * lat_chunk;
                len = lat_size - off;
                if (len > lat_chunk) len = lat_chunk;
                fl = FLAG_W'(lat_flags) & ~(FL_FIRST | FL_LAST | FL_PARITY);
                if (off == 0) fl |= FL_FIRST;
                if (off + len >= lat_size) fl |= FL_LAST;
                grp = lat_ilv ? cur_chunk % group_total : cur_chunk / GROUP_SIZE;
                parity_mem[grp*MAX_CHUNK_BYTES + in_chunk] ^= bv;
                pend = (in_chunk + 1 >= len);
                r.out_byte           = bv;
                r.packet_flags       = fl;
                r.chunk_number       = NUM_W'(cur_chunk);
                r.chunks_in_frame    = TOT_W'(chunk_total);
                r.chunk_start_offset = OFF_W'(off);
                r.chunk_length       = LEN_W'(len);
                r.packet_end         = pend;
                bytes_seen++;
                if (pend) begin
                    cur_chunk++;
                    in_chunk = 0;
                end else begin
                    in_chunk++;
                end
                if (bytes_seen >= lat_size) begin
                    phase     = PH_DRAIN;
                    drain_grp = 0;
                    drain_pos = 0;
                end
                return 1'b1;
            end
            CMD_DRAIN: begin
                if (phase != PH_DRAIN) return 1'b0;
                first = lat_ilv ? drain_grp : drain_grp * GROUP_SIZE;
                fl = (FLAG_W'(lat_flags) & ~(FL_FIRST | FL_LAST)) | FL_PARITY;
                if (lat_ilv) fl |= FL_ILV;
                pend = (drain_pos + 1 >= lat_chunk);
                done = pend && (drain_grp + 1 >= group_total);
                r.out_byte           = parity_mem[drain_grp*MAX_CHUNK_BYTES + drain_pos];
                r.packet_flags       = fl;
                r.chunk_number       = NUM_W'(first);
                r.chunks_in_frame    = TOT_W'(chunk_total);
                r.chunk_start_offset = OFF_W'(first * lat_chunk);
                r.chunk_length       = LEN_W'(lat_chunk);
                r.packet_end         = pend;
                r.frame_done         = done;
                if (pend) begin
                    drain_grp++;
                    drain_pos = 0;
                end else begin
                    drain_pos++;
                end
                if (done) phase = PH_IDLE;
                return 1'b1;
            end
            default: return 1'b0;
        endcase
    endfunction

    task automatic report_mismatch(input string what, input longint got, input longint want);
        err_cnt++;
        $display("[%0t] %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
    endtask

    // Result side: score each accepted result, then pick the ready for the next cycle.
    always @(posedge i_clk) begin
        t_out want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_q.size() == 0) begin
                report_mismatch("unexpected result, byte", out_ch.out_byte, 0);
            end else begin
                want = expected_q.pop_front();
                if (out_ch.out_byte !== want.out_byte)
                    report_mismatch("out_byte", out_ch.out_byte, want.out_byte);
                if (out_ch.packet_flags !== want.packet_flags)
                    report_mismatch("packet_flags", out_ch.packet_flags, want.packet_flags);
                if (out_ch.chunk_number !== want.chunk_number)
                    report_mismatch("chunk_number", out_ch.chunk_number, want.chunk_number);
                if (out_ch.chunks_in_frame !== want.chunks_in_frame)
                    report_mismatch("chunks_in_frame", out_ch.chunks_in_frame,
                                    want.chunks_in_frame);
                if (out_ch.chunk_start_offset !== want.chunk_start_offset)
                    report_mismatch("chunk_start_offset", out_ch.chunk_start_offset,
                                    want.chunk_start_offset);
                if (out_ch.chunk_length !== want.chunk_length)
                    report_mismatch("chunk_length", out_ch.chunk_length, want.chunk_length);
                if (out_ch.packet_end !== want.packet_end)
                    report_mismatch("packet_end", out_ch.packet_end, want.packet_end);
                if (out_ch.frame_done !== want.frame_done)
                    report_mismatch("frame_done", out_ch.frame_done, want.frame_done);
                if (out_ch.status !== want.status)
                    report_mismatch("status", out_ch.status, want.status);
            end
        end
        out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    end

    // Watchdog: stop a hung run.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("chunk_packetizer_xor_fec: mismatch");
            $finish;
        end
    end

    // Drive one request, hold it until accepted, then log what it should produce.
    // Valid stays high on exit so back-to-back requests need no second assignment.
    task automatic send_req(input logic [CMD_W-1:0] cmd, input logic [BYTE_W-1:0] bv,
                            input logic [PSZ_W-1:0] psz, input logic [FLAG_W-1:0] bfl,
                            input bit typed, input t_out typed_exp, output bit produced);
        int gap;
        t_out r;
        gap = 0;
        while ($urandom_range(99) < src_gap_pct) gap++;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.command      <= cmd;
        in_ch.byte_value   <= bv;
        in_ch.payload_size <= psz;
        in_ch.base_flags   <= bfl;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        produced = packetize(cmd, bv, psz, bfl, r);
        if (typed) expected_q.push_back(typed_exp);
        else if (produced) expected_q.push_back(r);
    endtask

    // Drop valid, drain every expected result, then let the pipe go quiet.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= val;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == REG_CHUNK_BYTES) reg_chunk_bytes = 32'(val);
        else reg_interleave = val[0];
        @(posedge i_clk);
    endtask

    function automatic t_stim_row req_row(input logic [CMD_W-1:0] cmd,
                                          input logic [BYTE_W-1:0] bv,
                                          input logic [PSZ_W-1:0] psz,
                                          input logic [FLAG_W-1:0] bfl, input int reps);
        t_stim_row s;
        s = '{ROW_REQ, cmd, bv, psz, bfl, reps, 1'b0, '0, '0, '0};
        return s;
    endfunction

    // Status reports carry zero in every field but frame_done and status.
    function automatic t_stim_row status_row(input logic [CMD_W-1:0] cmd,
                                             input logic [PSZ_W-1:0] psz,
                                             input logic [ST_W-1:0] st);
        t_stim_row s;
        s = '{ROW_REQ, cmd, 8'h5A, psz, 16'hFFFF, 1, 1'b1, '0, '0, '0};
        s.exp.frame_done = 1'b1;
        s.exp.status     = st;
        return s;
    endfunction

    function automatic t_stim_row cfg_row(input logic [CFG_IDX_W-1:0] idx,
                                          input logic [CFG_W-1:0] val);
        t_stim_row s;
        s = '{ROW_CFG, CMD_BYTE, '0, '0, '0, 1, 1'b0, '0, idx, val};
        return s;
    endfunction

    // Random request shaped by the predicted phase: mostly well-formed frames,
    // a sprinkling of aborts, stray ticks, unused commands and bad sizes.
    task automatic random_req(output bit produced);
        int unsigned roll, cs, max_bytes;
        logic [CMD_W-1:0]  cmd;
        logic [PSZ_W-1:0]  psz;
        t_out none;
        none = '0;
        roll = $urandom_range(99);
        psz  = PSZ_W'($urandom);
        cmd  = CMD_BYTE;
        cs   = (reg_chunk_bytes > MAX_CHUNK_BYTES) ? MAX_CHUNK_BYTES : reg_chunk_bytes;
        case (phase)
            PH_IDLE: begin
                max_bytes = cs * MAX_CHUNKS;
                if (roll < 3) begin
                    cmd = CMD_W'($urandom_range(3));
                end else if (roll < 6) begin
                    // bad size: zero or more chunks than allowed
                    psz = PSZ_W'(($urandom_range(1) == 0) ? 0 :
                                 $urandom_range(max_bytes + 1, (1 << PSZ_W) - 1));
                end else if (roll < 16 && cs <= 3) begin
                    psz = PSZ_W'(max_bytes);       // full 64-chunk frame
                end else begin
                    psz = PSZ_W'($urandom_range(1, (max_bytes < 96) ? max_bytes : 96));
                end
            end
            PH_DATA: begin
                if (roll < 2) cmd = CMD_ABORT;
                else if (roll < 4) cmd = ($urandom_range(1) == 0) ? CMD_DRAIN : CMD_UNUSED;
            end
            default: begin
                if (roll < 2) cmd = CMD_BYTE;
                else if (roll < 3) cmd = CMD_ABORT;
                else if (roll < 4) cmd = CMD_UNUSED;
                else cmd = CMD_DRAIN;
            end
        endcase
        send_req(cmd, BYTE_W'($urandom), psz, FLAG_W'($urandom), 1'b0, none, produced);
    endtask

    initial begin
        t_stim_row tab[$];
        int unsigned cs_pick[8] = '{1, 3, 16, 2, 7, 5, 12, 4};
        int stall_pick[4][2] = '{'{0, 0}, '{48, 0}, '{0, 48}, '{26, 26}};
        int done_items;
        bit produced;

        foreach (parity_mem[i]) parity_mem[i] = '0;
        in_ch.valid        <= 1'b0;
        in_ch.command      <= CMD_BYTE;
        in_ch.byte_value   <= '0;
        in_ch.payload_size <= '0;
        in_ch.base_flags   <= '0;

        // Hold reset, then release it.
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, reset register values first.
        tab.push_back(req_row(CMD_ABORT, 8'h00, 18'd0, 16'h0000, 1));  // abort while idle
        tab.push_back(req_row(CMD_DRAIN, 8'h00, 18'd0, 16'h0000, 1));  // tick while idle
        tab.push_back(req_row(CMD_UNUSED, 8'hFF, 18'h3FFFF, 16'hFFFF, 1));
        tab.push_back(status_row(CMD_BYTE, 18'd0, ST_BADSIZE));        // zero size
        tab.push_back(status_row(CMD_BYTE, 18'h3FFFF, ST_BADSIZE));    // too many chunks
        tab.push_back(req_row(CMD_BYTE, 8'hFF, 18'd2, 16'hFFFF, 1));
        tab.push_back(req_row(CMD_BYTE, 8'h00, 18'd0, 16'h0000, 1));
        tab.push_back(req_row(CMD_BYTE, 8'h77, 18'd9, 16'h1234, 1));  // byte while draining
        tab.push_back(req_row(CMD_UNUSED, 8'h00, 18'd0, 16'h0000, 1));
        tab.push_back(req_row(CMD_DRAIN, 8'h00, 18'd0, 16'h0000, 3));
        tab.push_back(status_row(CMD_ABORT, 18'd0, ST_ABORTED));       // abort mid-drain
        tab.push_back(cfg_row(REG_CHUNK_BYTES, 12'd0));
        tab.push_back(status_row(CMD_BYTE, 18'd5, ST_BADSIZE));        // zero chunk size
        tab.push_back(cfg_row(REG_CHUNK_BYTES, 12'hFFF));              // saturates to 2048
        tab.push_back(cfg_row(REG_INTERLEAVE, 12'd1));
        tab.push_back(status_row(CMD_BYTE, 18'd131073, ST_BADSIZE));   // 65 chunks of 2048
        tab.push_back(req_row(CMD_BYTE, 8'hA5, 18'd1, 16'h0036, 1));
        tab.push_back(req_row(CMD_DRAIN, 8'h00, 18'd0, 16'h0000, 4));  // head of a 2048 packet
        tab.push_back(status_row(CMD_ABORT, 18'd0, ST_ABORTED));
        tab.push_back(cfg_row(REG_CHUNK_BYTES, 12'd1));
        tab.push_back(req_row(CMD_BYTE, 8'hC3, 18'd64, 16'h8001, MAX_CHUNKS));
        tab.push_back(req_row(CMD_DRAIN, 8'h00, 18'd0, 16'h0000, GROUPS_MAX));

        foreach (tab[i]) begin
            if (tab[i].kind == ROW_CFG) begin
                settle();
                write_reg(tab[i].reg_idx, tab[i].reg_val);
            end else begin
                repeat (tab[i].reps)
                    send_req(tab[i].cmd, tab[i].bval, tab[i].psz, tab[i].bflags,
                             tab[i].typed, tab[i].exp, produced);
            end
        end

        // Random part: each stall setting runs two register settings.
        done_items = 0;
        for (int seg = 0; seg < 8; seg++) begin
            settle();
            src_gap_pct   = stall_pick[seg/2][0];
            snk_stall_pct = stall_pick[seg/2][1];
            write_reg(REG_CHUNK_BYTES, CFG_W'(cs_pick[seg]));
            write_reg(REG_INTERLEAVE, CFG_W'(seg % 2));
            while (done_items < (seg + 1) * RANDOM_ITEMS / 8) begin
                random_req(produced);
                if (produced) done_items++;
            end
            // close any open frame so the next register write lands while idle
            if (phase != PH_IDLE) begin
                send_req(CMD_ABORT, '0, '0, '0, 1'b0, '0, produced);
            end
        end

        settle();
        if (err_cnt == 0) begin
            $display("chunk_packetizer_xor_fec: match");
        end else begin
            $display("chunk_packetizer_xor_fec: mismatch");
        end
        $finish;
    end

endmodule
